[design/ugs_pkg.sv]
`timescale 1ns / 1ps
package ugs_pkg;

  localparam int DEPTH_MAX   = 32;
  localparam int LATERAL_MAX = 32;
  localparam int ANGLE_MAX   = 32;
  localparam int GRID_WORDS  = DEPTH_MAX * LATERAL_MAX * ANGLE_MAX;
  localparam int AW          = $clog2(GRID_WORDS);

  localparam int IDXW = 5;   // index field width
  localparam int CNTW = 6;   // count register width

  // accumulator: six terms below 2^47 plus a 32-bit source
  localparam int ACCW  = 52;
  localparam int DIAGW = 34;
  localparam int DVDW  = ACCW + 16;

  // register indexes
  localparam logic [2:0] REG_DEPTH_COUNT   = 3'd0;
  localparam logic [2:0] REG_LATERAL_COUNT = 3'd1;
  localparam logic [2:0] REG_ANGLE_COUNT   = 3'd2;
  localparam logic [2:0] REG_NEG_INV_DEPTH = 3'd3;
  localparam logic [2:0] REG_NEG_INV_LAT   = 3'd4;
  localparam logic [2:0] REG_NEG_INV_ANGLE = 3'd5;
  localparam logic [2:0] REG_QUANTITY      = 3'd6;

  // quantity codes that add a source term
  localparam logic [2:0] QTY_TIME   = 3'd2;
  localparam logic [2:0] QTY_LENGTH = 3'd4;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  function automatic logic [AW-1:0] grid_addr(input logic [IDXW-1:0] z,
                                              input logic [IDXW-1:0] x,
                                              input logic [IDXW-1:0] a);
    grid_addr = AW'((AW'(a) * AW'(LATERAL_MAX) + AW'(x)) * AW'(DEPTH_MAX) + AW'(z));
  endfunction

endpackage

[design/upwind_gauss_seidel_cell_update.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid_i/in_ready_o  | req_type, indices, value, rates, sources
// out     | output    | out_valid_o/out_ready_i| updated_value, zero_diagonal
// cfg     | input     | cfg_we_i (no wait)     | cfg_idx_i, cfg_data_i
//
// Write: the grid is written at the accept edge.
// Update: coefficient phase, neighbor reads on the single grid read port, the
// bit-serial divider, output load, then idle before the next accept.
// Zero diagonal skips the divider.
// Output stall: a finished update waits in S_FIN until the output register frees.
// Reset clears control and config; the grid is not cleared.
module upwind_gauss_seidel_cell_update (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [ugs_pkg::IDXW-1:0]        depth_index_i,
  input  logic [ugs_pkg::IDXW-1:0]        lateral_index_i,
  input  logic [ugs_pkg::IDXW-1:0]        angle_index_i,
  input  logic signed [31:0]              cell_value_i,
  input  logic signed [31:0]              depth_rate_i,
  input  logic signed [31:0]              lateral_rate_i,
  input  logic signed [31:0]              angle_rate_i,
  input  logic signed [31:0]              time_source_i,
  input  logic signed [31:0]              length_source_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [31:0]              updated_value_o,
  output logic                            zero_diagonal_o,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [31:0]                     cfg_data_i
);
  import ugs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COEF = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // config
  logic [CNTW-1:0]    nz_cfg_q, nx_cfg_q, na_cfg_q;
  logic signed [31:0] sz_q, sx_q, sa_q;
  logic [2:0]         qty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_cfg_q <= CNTW'(32);
      nx_cfg_q <= CNTW'(32);
      na_cfg_q <= CNTW'(32);
      sz_q     <= -32'sd65536;
      sx_q     <= -32'sd65536;
      sa_q     <= -32'sd65536;
      qty_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEPTH_COUNT:   nz_cfg_q <= cfg_data_i[CNTW-1:0];
        REG_LATERAL_COUNT: nx_cfg_q <= cfg_data_i[CNTW-1:0];
        REG_ANGLE_COUNT:   na_cfg_q <= cfg_data_i[CNTW-1:0];
        REG_NEG_INV_DEPTH: sz_q     <= cfg_data_i;
        REG_NEG_INV_LAT:   sx_q     <= cfg_data_i;
        REG_NEG_INV_ANGLE: sa_q     <= cfg_data_i;
        REG_QUANTITY:      qty_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // effective counts and clamped indices
  function automatic logic [CNTW-1:0] eff(input logic [CNTW-1:0] c, input int mx);
    if (c < CNTW'(2)) eff = CNTW'(2);
    else if (c > CNTW'(mx)) eff = CNTW'(mx);
    else eff = c;
  endfunction

  function automatic logic [IDXW-1:0] clampi(input logic [IDXW-1:0] i,
                                             input logic [CNTW-1:0] n);
    logic [CNTW-1:0] nm1;
    nm1 = n - 1'b1;
    clampi = ({1'b0, i} >= n) ? nm1[IDXW-1:0] : i;
  endfunction

  logic [CNTW-1:0] nz, nx, na, nzm1, nxm1, nam1;
  logic [IDXW-1:0] zi, xi, ai;
  assign nz   = eff(nz_cfg_q, DEPTH_MAX);
  assign nx   = eff(nx_cfg_q, LATERAL_MAX);
  assign na   = eff(na_cfg_q, ANGLE_MAX);
  assign nzm1 = nz - 1'b1;
  assign nxm1 = nx - 1'b1;
  assign nam1 = na - 1'b1;
  assign zi   = clampi(depth_index_i, nz);
  assign xi   = clampi(lateral_index_i, nx);
  assign ai   = clampi(angle_index_i, na);

  // control
  logic [2:0]         state_q;
  logic [2:0]         cnt_q;
  logic               acc_in;
  logic [IDXW-1:0]    z_q, x_q, a_q;
  logic signed [31:0] rz_q, rx_q, ra_q, src_q;
  logic signed [31:0] cz_q, cx_q, ca_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [64:0] prod_q;
  logic               out_valid_q, zero_q;
  logic signed [31:0] res_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc_in     = in_valid_i && in_ready_o;

  // grid memory, one write port and one read port, registered read
  logic [31:0]   grid_mem [GRID_WORDS];
  logic [31:0]   rdata_q;
  logic [AW-1:0] raddr;

  always_ff @(posedge clk_i) begin
    if (acc_in && req_type_i == REQ_WRITE) grid_mem[grid_addr(zi, xi, ai)] <= cell_value_i;
    rdata_q <= grid_mem[raddr];
  end

  // coefficient parts
  function automatic logic [31:0] pos_p(input logic signed [31:0] c);
    pos_p = (c > 0) ? c : '0;
  endfunction
  function automatic logic [31:0] neg_p(input logic signed [31:0] c);
    neg_p = (c < 0) ? 32'(-c) : '0;
  endfunction

  logic [DIAGW-1:0] diag;
  assign diag = DIAGW'(pos_p(cz_q)) + DIAGW'(neg_p(cz_q)) + DIAGW'(pos_p(cx_q))
              + DIAGW'(neg_p(cx_q)) + DIAGW'(pos_p(ca_q)) + DIAGW'(neg_p(ca_q));

  // neighbor slots: z+, z-, x+, x-, a+, a-
  logic [IDXW-1:0] zn, xn, an;
  logic [31:0]     part;
  logic            slot_ok;

  always_comb begin
    zn = z_q; xn = x_q; an = a_q; part = '0; slot_ok = 1'b1;
    case (cnt_q)
      3'd0: begin
        zn = (z_q == IDXW'(0)) ? IDXW'(1) : z_q + 1'b1;
        part = pos_p(cz_q);
        slot_ok = ({1'b0, z_q} != nzm1);
      end
      3'd1: begin
        zn = ({1'b0, z_q} == nzm1) ? IDXW'(nz - 2'd2) : z_q - 1'b1;
        part = neg_p(cz_q);
        slot_ok = (z_q != IDXW'(0));
      end
      3'd2: begin
        xn = (x_q == IDXW'(0)) ? IDXW'(1) : x_q + 1'b1;
        part = pos_p(cx_q);
        slot_ok = ({1'b0, x_q} != nxm1);
      end
      3'd3: begin
        xn = ({1'b0, x_q} == nxm1) ? IDXW'(nx - 2'd2) : x_q - 1'b1;
        part = neg_p(cx_q);
        slot_ok = (x_q != IDXW'(0));
      end
      3'd4: begin
        an = ({1'b0, a_q} == nam1) ? '0 : a_q + 1'b1;
        part = pos_p(ca_q);
      end
      3'd5: begin
        an = (a_q == '0) ? nam1[IDXW-1:0] : a_q - 1'b1;
        part = neg_p(ca_q);
      end
      default: slot_ok = 1'b0;
    endcase
  end

  assign raddr = grid_addr(zn, xn, an);

  // part and valid of the slot whose read data arrives now
  logic [31:0] part_q;
  logic        ok_q;
  always_ff @(posedge clk_i) begin
    part_q <= part;
    ok_q   <= slot_ok;
  end

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] shr;
  logic signed [31:0] sat_c;

  always_comb begin
    mul_a = {1'b0, part_q};
    mul_b = ok_q ? rdata_q : '0;
    if (state_q == S_COEF) begin
      case (cnt_q)
        3'd0:    begin mul_a = 33'(sz_q); mul_b = rz_q; end
        3'd1:    begin mul_a = 33'(sx_q); mul_b = rx_q; end
        default: begin mul_a = 33'(sa_q); mul_b = ra_q; end
      endcase
    end
  end

  assign shr   = prod_q >>> 16;
  assign sat_c = (shr > 65'sd2147483647) ? 32'h7fffffff :
                 (shr < -65'sd2147483648) ? 32'h80000000 : shr[31:0];

  // divider; the last neighbor term lands in the same cycle the divider starts
  logic                   div_start, div_done;
  logic [DVDW-1:0]        quot;
  logic signed [ACCW-1:0] acc_fin;
  logic [ACCW-1:0]        mag;
  logic                   neg_q;
  assign acc_fin = acc_q + ACCW'(shr);
  assign mag     = acc_fin[ACCW-1] ? ACCW'(-acc_fin) : ACCW'(acc_fin);

  ugs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag, 16'd0}),
    .divisor_i  (diag),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  logic signed [31:0] qres;
  always_comb begin
    if (neg_q) qres = (quot > DVDW'(64'h80000000)) ? 32'h80000000 : 32'(-quot);
    else       qres = (quot > DVDW'(64'h7fffffff)) ? 32'h7fffffff : quot[31:0];
  end

  logic [2:0] state_d;
  logic       last_read;
  logic       fin_load;
  assign last_read = (state_q == S_READ) && (cnt_q == 3'd7);
  assign div_start = last_read && (diag != '0);
  assign fin_load  = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (acc_in && req_type_i == REQ_UPDATE) state_d = S_COEF;
      S_COEF: if (cnt_q == 3'd3) state_d = S_READ;
      S_READ: if (last_read) state_d = (diag == '0) ? S_FIN : S_DIV;
      S_DIV:  if (div_done) state_d = S_FIN;
      S_FIN:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) cnt_q <= '0;
      else cnt_q <= cnt_q + 1'b1;
      if (fin_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (acc_in) begin
      z_q   <= zi;
      x_q   <= xi;
      a_q   <= ai;
      rz_q  <= depth_rate_i;
      rx_q  <= lateral_rate_i;
      ra_q  <= angle_rate_i;
      src_q <= (qty_q == QTY_TIME)   ? time_source_i :
               (qty_q == QTY_LENGTH) ? length_source_i : '0;
    end
    if (state_q == S_COEF) begin
      case (cnt_q)
        3'd1:    cz_q <= sat_c;
        3'd2:    cx_q <= sat_c;
        3'd3:    ca_q <= sat_c;
        default: ;
      endcase
    end
    if (state_q == S_COEF) acc_q <= ACCW'(src_q);
    else if (state_q == S_READ && cnt_q >= 3'd2) acc_q <= acc_fin;
    if (div_start) neg_q <= acc_fin[ACCW-1];
    // output word changes only when the previous one has been taken
    if (fin_load) begin
      res_q  <= (diag == '0) ? '0 : qres;
      zero_q <= (diag == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign updated_value_o = res_q;
  assign zero_diagonal_o = zero_q;

endmodule

[design/ugs_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module ugs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ugs_pkg::DVDW-1:0]  dividend_i,
  input  logic [ugs_pkg::DIAGW-1:0] divisor_i,
  output logic                      done_o,
  output logic [ugs_pkg::DVDW-1:0]  quot_o
);
  import ugs_pkg::*;

  localparam int CW = $clog2(DVDW + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DIAGW-1:0] rem_q, div_q;
  logic [DVDW-1:0]  quo_q;
  logic [DIAGW:0]   sh;
  logic             ge;

  assign sh = {rem_q, quo_q[DVDW-1]};
  assign ge = sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DVDW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? DIAGW'(sh - {1'b0, div_q}) : sh[DIAGW-1:0];
      quo_q <= {quo_q[DVDW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
